// ----- rtl/ppr_pkg.sv -----
`default_nettype none

package ppr_pkg;

	// Debounce defaults, in samples.
	localparam int unsigned TripDebounceDefault  = 3;
	localparam int unsigned ClearDebounceDefault = 10;

	// Mode codes.
	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_NORMAL = 3'd1;
	localparam logic [2:0] MODE_PULSE  = 3'd2;
	localparam logic [2:0] MODE_COOL   = 3'd3;
	localparam logic [2:0] MODE_FAULT  = 3'd4;

	// Fault cause codes.
	localparam logic [2:0] CAUSE_NONE    = 3'd0;
	localparam logic [2:0] CAUSE_SENSOR  = 3'd1;
	localparam logic [2:0] CAUSE_OVER    = 3'd2;
	localparam logic [2:0] CAUSE_SUPPLY  = 3'd3;
	localparam logic [2:0] CAUSE_TIMEOUT = 3'd4;

	// Register indexes on the configuration port (byte address = 4 * index).
	localparam logic [2:0] REG_OVER_TRIP    = 3'd0;
	localparam logic [2:0] REG_OVER_CLEAR   = 3'd1;
	localparam logic [2:0] REG_SUPPLY_TRIP  = 3'd2;
	localparam logic [2:0] REG_SUPPLY_CLEAR = 3'd3;
	localparam logic [2:0] REG_FUEL_LIMIT   = 3'd4;
	localparam logic [2:0] REG_PULSE_WIDTH  = 3'd5;
	localparam logic [2:0] REG_COOLDOWN     = 3'd6;
	localparam logic [2:0] REG_MAX_EPISODE  = 3'd7;

	localparam int unsigned PaddrWidth = 5;
	localparam int unsigned CountWidth = 8;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [15:0] fuel_pressure;
		logic signed [15:0] primary_pressure;
		logic signed [15:0] secondary_pressure;
		logic [2:0]         sensors_valid;
	} ppr_in_t;

	typedef struct packed {
		logic       valve_open;
		logic [2:0] mode;
		logic [2:0] fault_cause;
	} ppr_out_t;

endpackage

`default_nettype wire

// ----- rtl/pressure_pulse_regulator_with_faults.sv -----
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------
// in       | input     | in_valid/in_stall  | in_data  (ppr_in_t): one sample
// out      | output    | out_valid/out_stall| out_data (ppr_out_t): one result
// apb      | input     | psel/penable/...   | eight threshold/timing registers
//
// Each sample beat lands in an input register, and the whole safety check,
// debounce and mode update run combinationally from there into the result
// register. A sample goes through the input register and then the result
// register, and a new sample can be taken every cycle unless a held result
// stalls the input side. The 32-bit elapsed-time subtracts and compares lie
// on the combinational path between the two registers. Reset clears the mode
// machine, the debounce counters, the episode and pulse flags and both valid
// bits; the configuration registers return to their documented defaults. A
// stall on the result side holds the result register, and the input side
// stalls only when a sample is waiting behind a held result.

module pressure_pulse_regulator_with_faults
	import ppr_pkg::*;
#(
	parameter int unsigned TRIP_DEBOUNCE  = TripDebounceDefault,
	parameter int unsigned CLEAR_DEBOUNCE = ClearDebounceDefault
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire ppr_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output ppr_out_t                   out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PaddrWidth-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam logic [CountWidth-1:0] CountMax  = {CountWidth{1'b1}};
	localparam logic [CountWidth-1:0] TripLimit = CountWidth'(TRIP_DEBOUNCE);
	localparam logic [CountWidth-1:0] ClearLimit = CountWidth'(CLEAR_DEBOUNCE);

	// Configuration registers.
	logic [14:0] over_trip_q, over_clear_q, supply_trip_q, supply_clear_q, fuel_limit_q;
	logic [15:0] pulse_width_q, cooldown_q;
	logic [31:0] max_episode_q;

	logic [2:0] reg_idx;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_trip_q    <= 15'd9000;
			over_clear_q   <= 15'd8500;
			supply_trip_q  <= 15'd3000;
			supply_clear_q <= 15'd3500;
			fuel_limit_q   <= 15'd5000;
			pulse_width_q  <= 16'd50;
			cooldown_q     <= 16'd200;
			max_episode_q  <= 32'd10000;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_OVER_TRIP:    over_trip_q    <= pwdata[14:0];
				REG_OVER_CLEAR:   over_clear_q   <= pwdata[14:0];
				REG_SUPPLY_TRIP:  supply_trip_q  <= pwdata[14:0];
				REG_SUPPLY_CLEAR: supply_clear_q <= pwdata[14:0];
				REG_FUEL_LIMIT:   fuel_limit_q   <= pwdata[14:0];
				REG_PULSE_WIDTH:  pulse_width_q  <= pwdata[15:0];
				REG_COOLDOWN:     cooldown_q     <= pwdata[15:0];
				REG_MAX_EPISODE:  max_episode_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OVER_TRIP:    prdata = {17'd0, over_trip_q};
			REG_OVER_CLEAR:   prdata = {17'd0, over_clear_q};
			REG_SUPPLY_TRIP:  prdata = {17'd0, supply_trip_q};
			REG_SUPPLY_CLEAR: prdata = {17'd0, supply_clear_q};
			REG_FUEL_LIMIT:   prdata = {17'd0, fuel_limit_q};
			REG_PULSE_WIDTH:  prdata = {16'd0, pulse_width_q};
			REG_COOLDOWN:     prdata = {16'd0, cooldown_q};
			REG_MAX_EPISODE:  prdata = max_episode_q;
			default:          prdata = 32'd0;
		endcase
	end

	// Input register and result register with their valid bits.
	ppr_in_t  in_s1;
	logic     in_vld_s1;
	ppr_out_t out_s2;
	logic     out_vld_s2;
	logic     advance;

	assign advance   = in_vld_s1 && (!out_vld_s2 || !out_stall);
	assign in_stall  = in_vld_s1 && !advance;
	assign out_valid = out_vld_s2;
	assign out_data  = out_s2;

	// Regulator state.
	logic [2:0]            mode_q, latched_q, pending_q;
	logic [CountWidth-1:0] trip_cnt_q, clear_cnt_q;
	logic                  episode_act_q, pulse_act_q;
	logic [31:0]           episode_start_q, cooldown_start_q, pulse_start_q;

	// Next-state values for the sample in the input register.
	logic [2:0]            mode_d, latched_d, pending_d, det;
	logic [CountWidth-1:0] trip_cnt_d, clear_cnt_d;
	logic                  episode_act_d, pulse_act_d, all_valid, episode_new;
	logic [31:0]           episode_start_d, cooldown_start_d, pulse_start_d;
	logic [31:0]           pulse_age, cool_age, episode_age;
	logic signed [15:0]    over_lim, supply_lim;

	assign all_valid   = (in_s1.sensors_valid == 3'b111);
	assign pulse_age   = in_s1.now_ms - pulse_start_q;
	assign cool_age    = in_s1.now_ms - cooldown_start_q;
	assign episode_age = in_s1.now_ms - episode_start_q;

	// The hysteresis band follows the latched cause.
	assign over_lim   = (latched_q == CAUSE_OVER) ? $signed({1'b0, over_clear_q})
	                                              : $signed({1'b0, over_trip_q});
	assign supply_lim = (latched_q == CAUSE_SUPPLY) ? $signed({1'b0, supply_clear_q})
	                                                : $signed({1'b0, supply_trip_q});

	always_comb begin
		if (!all_valid) begin
			det = CAUSE_SENSOR;
		end else if (in_s1.fuel_pressure > over_lim || in_s1.secondary_pressure > over_lim) begin
			det = CAUSE_OVER;
		end else if (in_s1.primary_pressure < supply_lim) begin
			det = CAUSE_SUPPLY;
		end else begin
			det = CAUSE_NONE;
		end
	end

	always_comb begin
		mode_d           = mode_q;
		latched_d        = latched_q;
		episode_act_d    = episode_act_q;
		episode_start_d  = episode_start_q;
		cooldown_start_d = cooldown_start_q;
		pulse_start_d    = pulse_start_q;
		episode_new      = 1'b0;

		// A running pulse ends once its width has elapsed.
		pulse_act_d = pulse_act_q && (pulse_age < {16'd0, pulse_width_q});

		// Debounce: streak counters saturate at their all-ones value.
		if (det != CAUSE_NONE) begin
			clear_cnt_d = '0;
			if (det == pending_q) begin
				trip_cnt_d = (trip_cnt_q == CountMax) ? trip_cnt_q : trip_cnt_q + 1'b1;
			end else begin
				trip_cnt_d = CountWidth'(1);
			end
			pending_d = det;
		end else begin
			trip_cnt_d  = '0;
			pending_d   = CAUSE_NONE;
			clear_cnt_d = (clear_cnt_q == CountMax) ? clear_cnt_q : clear_cnt_q + 1'b1;
		end

		if (mode_q == MODE_FAULT || (det != CAUSE_NONE && trip_cnt_d >= TripLimit)) begin
			// Entering or staying in fault keeps the valve shut.
			if (mode_q != MODE_FAULT) begin
				mode_d      = MODE_FAULT;
				latched_d   = det;
				trip_cnt_d  = '0;
				clear_cnt_d = '0;
			end
			pulse_act_d = 1'b0;
			if (clear_cnt_d >= ClearLimit) begin
				mode_d        = MODE_NORMAL;
				latched_d     = CAUSE_NONE;
				episode_act_d = 1'b0;
			end
		end else begin
			case (mode_q)
				MODE_INIT: begin
					if (all_valid) mode_d = MODE_NORMAL;
				end
				MODE_NORMAL: begin
					if (in_s1.fuel_pressure < $signed({1'b0, fuel_limit_q})) begin
						if (!episode_act_q) begin
							episode_act_d   = 1'b1;
							episode_start_d = in_s1.now_ms;
							episode_new     = 1'b1;
						end
						pulse_act_d   = 1'b1;
						pulse_start_d = in_s1.now_ms;
						mode_d        = MODE_PULSE;
					end else begin
						episode_act_d = 1'b0;
					end
				end
				MODE_PULSE: begin
					if (!pulse_act_d) begin
						mode_d           = MODE_COOL;
						cooldown_start_d = in_s1.now_ms;
					end
				end
				MODE_COOL: begin
					if (cool_age >= {16'd0, cooldown_q}) mode_d = MODE_NORMAL;
				end
				default: mode_d = MODE_INIT;
			endcase
			// An episode that starts on this sample has zero age and cannot time out.
			if (episode_act_d && !episode_new && episode_age > max_episode_q) begin
				mode_d      = MODE_FAULT;
				latched_d   = CAUSE_TIMEOUT;
				pulse_act_d = 1'b0;
				trip_cnt_d  = '0;
				clear_cnt_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1  <= 1'b0;
			out_vld_s2 <= 1'b0;
		end else begin
			if (!in_stall) in_vld_s1 <= in_valid;
			if (advance) begin
				out_vld_s2 <= 1'b1;
			end else if (!out_stall) begin
				out_vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) in_s1 <= in_data;
		if (advance) begin
			out_s2.valve_open  <= pulse_act_d;
			out_s2.mode        <= mode_d;
			out_s2.fault_cause <= latched_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_INIT;
			latched_q        <= CAUSE_NONE;
			pending_q        <= CAUSE_NONE;
			trip_cnt_q       <= '0;
			clear_cnt_q      <= '0;
			episode_act_q    <= 1'b0;
			pulse_act_q      <= 1'b0;
			episode_start_q  <= '0;
			cooldown_start_q <= '0;
			pulse_start_q    <= '0;
		end else if (advance) begin
			mode_q           <= mode_d;
			latched_q        <= latched_d;
			pending_q        <= pending_d;
			trip_cnt_q       <= trip_cnt_d;
			clear_cnt_q      <= clear_cnt_d;
			episode_act_q    <= episode_act_d;
			pulse_act_q      <= pulse_act_d;
			episode_start_q  <= episode_start_d;
			cooldown_start_q <= cooldown_start_d;
			pulse_start_q    <= pulse_start_d;
		end
	end

endmodule

`default_nettype wire

// ----- test/pressure_pulse_regulator_with_faults_test.sv -----
`timescale 1ns / 1ps

module pressure_pulse_regulator_with_faults_test
	import ppr_pkg::*;
();

	// A run of no beats on any port this long means the block has hung. The
	// worst quiet stretch is a full register reload (eight writes) or a long
	// run of result stalls at 88 percent, both far below this.
	localparam int unsigned HangLimit = 2000;

	// Shapes of generated samples. Healthy kinds keep every pressure inside
	// its thresholds. Fault kinds push exactly one check over its limit.
	typedef enum int {
		CALM,
		LOW_FUEL,
		EDGE,
		BAD_SENSOR,
		OVER,
		SUPPLY,
		NOISE
	} sample_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	ppr_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ppr_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PaddrWidth-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Samples waiting for the driver, and the status the regulator should
	// report for every sample beat already taken, oldest first.
	ppr_in_t samples_waiting[$];
	ppr_out_t predicted_status[$];

	int unsigned send_idle_pct = 10;
	int unsigned recv_idle_pct = 88;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic sample_taken = 1'b0;
	logic [31:0] clock_ms = '0;

	// Our copy of the configuration registers, starting at their reset values.
	logic [14:0] cfg_over_trip = 15'd9000;
	logic [14:0] cfg_over_clear = 15'd8500;
	logic [14:0] cfg_supply_trip = 15'd3000;
	logic [14:0] cfg_supply_clear = 15'd3500;
	logic [14:0] cfg_fuel_limit = 15'd5000;
	logic [15:0] cfg_pulse_width = 16'd50;
	logic [15:0] cfg_cooldown = 16'd200;
	logic [31:0] cfg_max_episode = 32'd10000;

	// Our copy of the regulator state: mode machine, debounce streaks,
	// drive episode and solenoid pulse.
	logic [2:0] st_mode = MODE_INIT;
	logic [2:0] st_cause = CAUSE_NONE;
	logic [2:0] st_pending = CAUSE_NONE;
	logic [7:0] st_trips = '0;
	logic [7:0] st_clears = '0;
	logic st_ep_on = 1'b0;
	logic [31:0] st_ep_t0 = '0;
	logic [31:0] st_cool_t0 = '0;
	logic st_pulse_on = 1'b0;
	logic [31:0] st_pulse_t0 = '0;

	pressure_pulse_regulator_with_faults u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Latching a fault closes the valve and restarts both debounce streaks.
	function automatic void trip_fault(input logic [2:0] cause);
		st_mode = MODE_FAULT;
		st_cause = cause;
		st_pulse_on = 1'b0;
		st_trips = '0;
		st_clears = '0;
	endfunction

	// Advances our copy of the regulator by one sample and returns the status
	// it reports afterwards. Elapsed times are plain 32-bit differences, so a
	// wrap of the millisecond counter needs no special handling.
	function automatic ppr_out_t predict_status(input ppr_in_t s);
		logic signed [15:0] fuel;
		logic signed [15:0] prim;
		logic signed [15:0] sec;
		logic signed [15:0] lim;
		logic all_ok;
		logic [2:0] found;
		ppr_out_t r;
		fuel = s.fuel_pressure;
		prim = s.primary_pressure;
		sec = s.secondary_pressure;
		all_ok = (s.sensors_valid == 3'b111);

		if (st_pulse_on && (s.now_ms - st_pulse_t0) >= {16'd0, cfg_pulse_width})
			st_pulse_on = 1'b0;

		// The clear thresholds apply only while that same cause is latched.
		if (!all_ok) begin
			found = CAUSE_SENSOR;
		end else begin
			lim = {1'b0, (st_cause == CAUSE_OVER) ? cfg_over_clear : cfg_over_trip};
			if (fuel > lim || sec > lim) begin
				found = CAUSE_OVER;
			end else begin
				lim = {1'b0, (st_cause == CAUSE_SUPPLY) ? cfg_supply_clear : cfg_supply_trip};
				found = (prim < lim) ? CAUSE_SUPPLY : CAUSE_NONE;
			end
		end

		// Streak counters saturate rather than wrap.
		if (found != CAUSE_NONE) begin
			st_clears = '0;
			if (found == st_pending) begin
				if (st_trips != 8'hFF)
					st_trips = st_trips + 8'd1;
			end else begin
				st_trips = 8'd1;
			end
			st_pending = found;
		end else begin
			st_trips = '0;
			st_pending = CAUSE_NONE;
			if (st_clears != 8'hFF)
				st_clears = st_clears + 8'd1;
		end

		if (st_mode != MODE_FAULT && found != CAUSE_NONE && st_trips >= TripDebounceDefault)
			trip_fault(found);

		if (st_mode == MODE_FAULT) begin
			st_pulse_on = 1'b0;
			if (st_clears >= ClearDebounceDefault) begin
				st_mode = MODE_NORMAL;
				st_cause = CAUSE_NONE;
				st_ep_on = 1'b0;
			end
		end else begin
			case (st_mode)
				MODE_INIT: begin
					if (all_ok)
						st_mode = MODE_NORMAL;
				end
				MODE_NORMAL: begin
					lim = {1'b0, cfg_fuel_limit};
					if (fuel < lim) begin
						if (!st_ep_on) begin
							st_ep_on = 1'b1;
							st_ep_t0 = s.now_ms;
						end
						st_pulse_on = 1'b1;
						st_pulse_t0 = s.now_ms;
						st_mode = MODE_PULSE;
					end else begin
						st_ep_on = 1'b0;
					end
				end
				MODE_PULSE: begin
					if (!st_pulse_on) begin
						st_mode = MODE_COOL;
						st_cool_t0 = s.now_ms;
					end
				end
				MODE_COOL: begin
					if ((s.now_ms - st_cool_t0) >= {16'd0, cfg_cooldown})
						st_mode = MODE_NORMAL;
				end
				default: begin
					st_mode = MODE_INIT;
				end
			endcase
			// The episode clock is not checked while a fault is latched.
			if (st_ep_on && (s.now_ms - st_ep_t0) > cfg_max_episode)
				trip_fault(CAUSE_TIMEOUT);
		end

		r.valve_open = st_pulse_on;
		r.mode = st_mode;
		r.fault_cause = st_cause;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sample generation
	// ------------------------------------------------------------------

	function automatic logic signed [15:0] sat16(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic int jitter(input int unsigned n);
		return int'($urandom_range(n));
	endfunction

	// Builds one sample around the thresholds now in force. Healthy samples
	// hold primary at or above the supply clear level and secondary below the
	// overpressure clear level; the other kinds then bend one or more fields.
	function automatic ppr_in_t make_sample(input sample_kind_t kind, input logic [31:0] at);
		ppr_in_t s;
		int over_t;
		int over_c;
		int sup_t;
		int sup_c;
		int fuel_lim;
		over_t = int'(cfg_over_trip);
		over_c = int'(cfg_over_clear);
		sup_t = int'(cfg_supply_trip);
		sup_c = int'(cfg_supply_clear);
		fuel_lim = int'(cfg_fuel_limit);
		s.now_ms = at;
		s.sensors_valid = 3'b111;
		s.fuel_pressure = sat16(fuel_lim + jitter(2000));
		s.primary_pressure = sat16(sup_c + jitter(3000));
		s.secondary_pressure = sat16(over_c - 1 - jitter(3000));
		case (kind)
			LOW_FUEL: begin
				s.fuel_pressure = sat16(fuel_lim - 1 - jitter(2000));
			end
			EDGE: begin
				// Straddle the limits by a count or two to catch off-by-one
				// compares and the hysteresis band.
				s.fuel_pressure = sat16(fuel_lim + jitter(4) - 2);
				s.secondary_pressure = sat16(($urandom_range(1) ? over_t : over_c) + jitter(4) - 2);
				s.primary_pressure = sat16(($urandom_range(1) ? sup_t : sup_c) + jitter(4) - 2);
			end
			BAD_SENSOR: begin
				s.sensors_valid = 3'($urandom_range(6));
			end
			OVER: begin
				if ($urandom_range(1))
					s.fuel_pressure = sat16(over_t + 1 + jitter(3000));
				else
					s.secondary_pressure = sat16(over_t + 1 + jitter(3000));
			end
			SUPPLY: begin
				s.primary_pressure = sat16(sup_t - 1 - jitter(3000));
			end
			NOISE: begin
				s.fuel_pressure = 16'($urandom);
				s.primary_pressure = 16'($urandom);
				s.secondary_pressure = 16'($urandom);
				s.sensors_valid = 3'($urandom);
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	task automatic queue_fixed(input logic [31:0] at, input int fuel, input int prim,
			input int sec, input logic [2:0] valid_bits);
		ppr_in_t s;
		s.now_ms = at;
		s.fuel_pressure = sat16(fuel);
		s.primary_pressure = sat16(prim);
		s.secondary_pressure = sat16(sec);
		s.sensors_valid = valid_bits;
		samples_waiting.push_back(s);
	endtask

	// Time mostly creeps forward a few milliseconds, sometimes jumps far
	// enough to end long pulses and cooldowns, and now and then lands
	// anywhere at all, wraps included.
	task automatic queue_sample(input sample_kind_t kind);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 2)
			clock_ms = $urandom;
		else if (pick < 12)
			clock_ms = clock_ms + $urandom_range(70000);
		else
			clock_ms = clock_ms + $urandom_range(8);
		samples_waiting.push_back(make_sample(kind, clock_ms));
	endtask

	// Mostly healthy stretches, often long enough to clear a latched fault, broken
	// by short fault bursts that may or may not outlast the trip debounce,
	// and a little pure noise.
	task automatic run_phase(input int count);
		int made;
		int run_len;
		int unsigned pick;
		int unsigned sub;
		sample_kind_t kind;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 60)
				run_len = $urandom_range(5, 25);
			else if (pick < 85)
				run_len = $urandom_range(1, 5);
			else
				run_len = $urandom_range(1, 3);
			sub = $urandom_range(2);
			for (int i = 0; i < run_len; i++) begin
				if (pick < 60) begin
					sub = $urandom_range(9);
					kind = (sub < 4) ? LOW_FUEL : (sub < 8) ? CALM : EDGE;
				end else if (pick < 85) begin
					kind = (sub == 0) ? BAD_SENSOR : (sub == 1) ? OVER : SUPPLY;
				end else begin
					kind = NOISE;
				end
				queue_sample(kind);
			end
			made += run_len;
		end
	endtask

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_OVER_TRIP: cfg_over_trip = value[14:0];
			REG_OVER_CLEAR: cfg_over_clear = value[14:0];
			REG_SUPPLY_TRIP: cfg_supply_trip = value[14:0];
			REG_SUPPLY_CLEAR: cfg_supply_clear = value[14:0];
			REG_FUEL_LIMIT: cfg_fuel_limit = value[14:0];
			REG_PULSE_WIDTH: cfg_pulse_width = value[15:0];
			REG_COOLDOWN: cfg_cooldown = value[15:0];
			REG_MAX_EPISODE: cfg_max_episode = value;
			default: begin
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] over_trip, input logic [31:0] over_clear,
			input logic [31:0] supply_trip, input logic [31:0] supply_clear,
			input logic [31:0] fuel_limit, input logic [31:0] pulse_width,
			input logic [31:0] cooldown, input logic [31:0] max_episode);
		apb_write(REG_OVER_TRIP, over_trip);
		apb_write(REG_OVER_CLEAR, over_clear);
		apb_write(REG_SUPPLY_TRIP, supply_trip);
		apb_write(REG_SUPPLY_CLEAR, supply_clear);
		apb_write(REG_FUEL_LIMIT, fuel_limit);
		apb_write(REG_PULSE_WIDTH, pulse_width);
		apb_write(REG_COOLDOWN, cooldown);
		apb_write(REG_MAX_EPISODE, max_episode);
	endtask

	// A plausible random setting: clear levels sit on the safe side of their
	// trip levels, pulses and cooldowns are short so that episodes build up
	// and time out often.
	task automatic configure_random();
		int unsigned over_t;
		int unsigned sup_t;
		over_t = $urandom_range(500, 20000);
		sup_t = $urandom_range(200, 6000);
		configure(over_t, over_t - $urandom_range(600), sup_t, sup_t + $urandom_range(600),
			$urandom_range(1000, 12000), $urandom_range(1, 20), $urandom_range(60),
			$urandom_range(10, 600));
	endtask

	// Holds off until every queued sample has gone in and every predicted
	// status has come back, then lets the pipeline settle.
	task automatic wait_drained();
		while (samples_waiting.size() != 0 || in_valid || predicted_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver, receiver and monitor
	// ------------------------------------------------------------------

	// The sample side moves on only once the current beat has been taken,
	// so a stalled payload stays put. Valid is decided without looking at
	// the stall.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || sample_taken)) begin
			if (samples_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= samples_waiting.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 100)
			$display("%0t ns: %s got %0d, predicted %0d", $realtime, field, got, want);
		mismatches++;
	endtask

	// At each rising edge the result beat is checked against the oldest
	// prediction first, then a sample beat taken at the same edge is run
	// through the predictor. The block registers each sample before its result,
	// so a result can never belong to the sample taken on its own edge.
	always @(posedge clk) begin : watch
		ppr_out_t want;
		sample_taken = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_status.size() == 0) begin
				report_mismatch("result beat with nothing predicted", 32'(out_data), '0);
			end else begin
				want = predicted_status.pop_front();
				if (out_data.valve_open !== want.valve_open)
					report_mismatch("valve_open", 32'(out_data.valve_open), 32'(want.valve_open));
				if (out_data.mode !== want.mode)
					report_mismatch("mode", 32'(out_data.mode), 32'(want.mode));
				if (out_data.fault_cause !== want.fault_cause)
					report_mismatch("fault_cause", 32'(out_data.fault_cause),
						32'(want.fault_cause));
			end
		end
		if (sample_taken)
			predicted_status.push_back(predict_status(in_data));
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == HangLimit) begin
			$display("pressure_pulse_regulator_with_faults_test: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed samples under the reset configuration. The first sample
		// at time zero takes the block out of Init; then a full pulse and
		// cooldown, the most negative fuel reading, a sensor fault through
		// each missing valid bit, clean samples sitting exactly on the trip
		// levels until the fault clears, a secondary overpressure held inside
		// its hysteresis band, the most negative primary and a last sample at
		// the top of the time range with no sensor valid.
		queue_fixed(32'd0, 6000, 4000, 0, 3'b111);
		queue_fixed(32'd1, 4999, 4000, 0, 3'b111);
		queue_fixed(32'd51, 6000, 4000, 0, 3'b111);
		queue_fixed(32'd251, 6000, 4000, 0, 3'b111);
		queue_fixed(32'd252, -32768, 32767, -32768, 3'b111);
		queue_fixed(32'd253, 6000, 4000, 0, 3'b110);
		queue_fixed(32'd254, 6000, 4000, 0, 3'b101);
		queue_fixed(32'd255, 6000, 4000, 0, 3'b011);
		queue_fixed(32'd256, 32767, 4000, 0, 3'b111);
		for (int i = 0; i < 10; i++)
			queue_fixed(32'd257 + 32'(i), 9000, 3000, 9000, 3'b111);
		for (int i = 0; i < 3; i++)
			queue_fixed(32'd267 + 32'(i), 6000, 4000, 9001, 3'b111);
		queue_fixed(32'd270, 6000, 4000, 8501, 3'b111);
		queue_fixed(32'd271, 6000, -32768, 8500, 3'b111);
		queue_fixed(32'hFFFF_FFFF, 32767, 32767, 32767, 3'b000);
		clock_ms = 32'd300;
		wait_drained();

		// Short pulses, cooldowns and episodes, so timeouts come often. The
		// sample side stops halfway until every status is back.
		configure(9000, 8500, 3000, 3500, 5000, 3, 5, 40);
		run_phase(90);
		wait_drained();
		run_phase(90);
		wait_drained();

		// Thresholds at their extremes the other way: fuel reads low unless it is
		// at full scale, no overpressure fault is possible, zero pulse width and
		// cooldown, the longest episode, and time starting just short of the wrap.
		configure(32767, 32767, 0, 0, 32767, 0, 0, 32'hFFFF_FFFF);
		clock_ms = 32'hFFFF_FF00;
		run_phase(180);
		wait_drained();

		send_idle_pct = 88;
		recv_idle_pct = 10;

		// Every limit at its most sensitive: nearly every sample faults and
		// any episode times out at once.
		configure(0, 0, 32767, 32767, 0, 65535, 65535, 0);
		run_phase(120);
		wait_drained();

		configure_random();
		run_phase(180);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;

		configure_random();
		run_phase(180);
		wait_drained();

		configure(9000, 8500, 3000, 3500, 5000, 50, 200, 10000);
		run_phase(230);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("pressure_pulse_regulator_with_faults_test: clean");
		else
			$display("pressure_pulse_regulator_with_faults_test: errors");
		$finish;
	end

endmodule
